@@ rtl/xmac_receive_frame_filter_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the receive frame filter.
// Both macros expect signals named clk and arst_n in the scope where they are
// used. Each macro reports through $error with the message it is given.
// ----------------------------------------------------------------------------
`ifndef XMAC_RECEIVE_FRAME_FILTER_CORE_MACROS_SVH
`define XMAC_RECEIVE_FRAME_FILTER_CORE_MACROS_SVH

// When ante holds at a clock edge, cons must hold at the same edge.
`define XMAC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// When ante holds at a clock edge, cons must hold at the next edge.
`define XMAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/xmac_rff_pkg.sv @@
// ----------------------------------------------------------------------------
// xmac_rff_pkg
// Shared types, codes and constants of the receive frame filter.
// ----------------------------------------------------------------------------
`default_nettype none

package xmac_rff_pkg;

	// Default depth of the ring of recently seen strobe ids.
	localparam int SEEN_DEPTH_DEF = 10;

	// Link header length in bytes; a data frame of exactly this length is empty.
	localparam logic [6:0] HEADER_BYTES = 7'd6;

	// Header type bytes.
	localparam logic [7:0] KIND_STROBE     = 8'h10;
	localparam logic [7:0] KIND_DATA       = 8'h11;
	localparam logic [7:0] KIND_STROBE_ACK = 8'h13;

	// Only valid dispatch byte.
	localparam logic [7:0] DISPATCH_OK = 8'h00;

	// Busy count loaded when a strobe is overheard.
	localparam logic [1:0] BUSY_STROBE_SEEN = 2'd2;
	// Waiting count limit after which a sleep tick gives up waiting.
	localparam logic [1:0] WAIT_LIMIT = 2'd2;

	// Configuration register indexes.
	localparam logic REG_MAC_ENABLED   = 1'b0;
	localparam logic REG_SLEEP_ENABLED = 1'b1;

	typedef enum logic [1:0] {
		OP_FRAME = 2'd0,
		OP_WAKE  = 2'd1,
		OP_SLEEP = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		DEST_SELF  = 2'd0,
		DEST_BCAST = 2'd1,
		DEST_OTHER = 2'd2
	} dest_t;

	typedef enum logic [3:0] {
		V_EMPTY          = 4'd0,
		V_PARSE_FAIL     = 4'd1,
		V_BAD_DISPATCH   = 4'd2,
		V_SHORT          = 4'd3,
		V_BAD_CHECKSUM   = 4'd4,
		V_DUP_STROBE     = 4'd5,
		V_SEND_ACK       = 4'd6,
		V_BCAST_LISTEN   = 4'd7,
		V_STROBE_OTHER   = 4'd8,
		V_ACK_SEEN       = 4'd9,
		V_ID_MISMATCH    = 4'd10,
		V_DATA_EMPTY     = 4'd11,
		V_DELIVER        = 4'd12,
		V_DATA_OTHER     = 4'd13,
		V_UNKNOWN_KIND   = 4'd14,
		V_TICK_DONE      = 4'd15
	} verdict_t;

	// One input beat as held in the input register.
	typedef struct packed {
		logic [1:0]  operation;
		logic [6:0]  frame_length;
		logic        parse_ok;
		logic [7:0]  dispatch_byte;
		logic [7:0]  frame_kind;
		logic [15:0] frame_ident;
		logic [7:0]  header_check;
		logic [1:0]  dest_kind;
		logic        sender_busy;
	} item_t;

	// Duty-cycle state that the decision logic reads and updates.
	typedef struct packed {
		logic        radio;
		logic [1:0]  busy_cnt;
		logic [1:0]  wait_cnt;
		logic [15:0] expected_ident;
	} mac_state_t;

endpackage

`default_nettype wire

@@ rtl/xmac_rff_ifs.sv @@
// ----------------------------------------------------------------------------
// xmac_rff item and result channels
// Valid/ready channels carrying input beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface xmac_rff_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [6:0]  frame_length;
	logic        parse_ok;
	logic [7:0]  dispatch_byte;
	logic [7:0]  frame_kind;
	logic [15:0] frame_ident;
	logic [7:0]  header_check;
	logic [1:0]  dest_kind;
	logic        sender_busy;

	modport source (
		output valid, operation, frame_length, parse_ok, dispatch_byte, frame_kind,
			frame_ident, header_check, dest_kind, sender_busy,
		input ready
	);
	modport sink (
		input valid, operation, frame_length, parse_ok, dispatch_byte, frame_kind,
			frame_ident, header_check, dest_kind, sender_busy,
		output ready
	);
endinterface

interface xmac_rff_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] verdict;
	logic       radio_on;
	logic [1:0] channel_busy_count;
	logic [1:0] waiting_count;

	modport source (
		output valid, verdict, radio_on, channel_busy_count, waiting_count,
		input ready
	);
	modport sink (
		input valid, verdict, radio_on, channel_busy_count, waiting_count,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/xmac_rff_seen.sv @@
// ----------------------------------------------------------------------------
// xmac_rff_seen
// Ring of recently seen strobe ids with a parallel match and a write pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module xmac_rff_seen import xmac_rff_pkg::*; #(
	parameter int SEEN_DEPTH = SEEN_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] ident,
	input  wire logic        insert,
	output logic             hit
);

	localparam int PTR_W = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SEEN_DEPTH - 1);

	logic [15:0]      ids_q [SEEN_DEPTH];
	logic [PTR_W-1:0] ptr_q;

	// All entries are compared at once; each entry is a fixed tap.
	always_comb begin
		hit = 1'b0;
		for (int k = 0; k < SEEN_DEPTH; k++) begin
			if (ids_q[k] == ident) begin
				hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SEEN_DEPTH; k++) begin
				ids_q[k] <= '0;
			end
			ptr_q <= '0;
		end else if (insert) begin
			ids_q[ptr_q] <= ident;
			ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
		end
	end

endmodule

`default_nettype wire

@@ rtl/xmac_rff_eval.sv @@
// ----------------------------------------------------------------------------
// xmac_rff_eval
// Decision logic: classifies one beat and computes the next duty-cycle state.
// ----------------------------------------------------------------------------
`default_nettype none

module xmac_rff_eval import xmac_rff_pkg::*; (
	input  wire item_t      item,
	input  wire mac_state_t cur,
	input  wire logic       mac_enabled,
	input  wire logic       sleep_enabled,
	input  wire logic       seen_hit,
	output mac_state_t      nxt,
	output verdict_t        verdict,
	output logic            seen_insert
);

	logic [7:0] calc_check;
	logic       for_us;

	assign calc_check = item.dispatch_byte ^ item.frame_kind ^
		item.frame_ident[15:8] ^ item.frame_ident[7:0];
	assign for_us = (item.dest_kind == DEST_SELF) || (item.dest_kind == DEST_BCAST);

	always_comb begin
		nxt         = cur;
		verdict     = V_TICK_DONE;
		seen_insert = 1'b0;
		unique case (item.operation)
			OP_FRAME: begin
				priority if (item.frame_length == 7'd0) begin
					verdict = V_EMPTY;
				end else if (!item.parse_ok) begin
					verdict = V_PARSE_FAIL;
				end else if (item.dispatch_byte != DISPATCH_OK) begin
					verdict = V_BAD_DISPATCH;
				end else if (item.frame_length < HEADER_BYTES) begin
					verdict = V_SHORT;
				end else if (item.header_check != calc_check) begin
					verdict = V_BAD_CHECKSUM;
				end else if (item.frame_kind == KIND_STROBE) begin
					nxt.busy_cnt = BUSY_STROBE_SEEN;
					priority if (item.dest_kind == DEST_SELF) begin
						if (seen_hit) begin
							verdict = V_DUP_STROBE;
						end else begin
							seen_insert        = 1'b1;
							nxt.expected_ident = item.frame_ident;
							nxt.busy_cnt       = 2'd1;
							nxt.wait_cnt       = 2'd1;
							nxt.radio          = 1'b1;
							verdict            = V_SEND_ACK;
						end
					end else if (item.dest_kind == DEST_BCAST) begin
						nxt.wait_cnt = 2'd1;
						if (mac_enabled) begin
							nxt.radio = 1'b1;
						end
						verdict = V_BCAST_LISTEN;
					end else begin
						verdict = V_STROBE_OTHER;
					end
				end else if (item.frame_kind == KIND_STROBE_ACK) begin
					verdict = V_ACK_SEEN;
				end else if (item.frame_kind == KIND_DATA) begin
					nxt.busy_cnt = 2'd0;
					priority if (item.frame_ident != cur.expected_ident) begin
						verdict = V_ID_MISMATCH;
					end else if (item.frame_length == HEADER_BYTES) begin
						verdict = V_DATA_EMPTY;
					end else begin
						nxt.wait_cnt = 2'd0;
						verdict      = for_us ? V_DELIVER : V_DATA_OTHER;
					end
				end else begin
					verdict = V_UNKNOWN_KIND;
				end
			end
			OP_WAKE: begin
				if (cur.busy_cnt != 2'd0) begin
					nxt.busy_cnt = cur.busy_cnt - 2'd1;
				end
				if (!item.sender_busy && cur.wait_cnt == 2'd0 && mac_enabled) begin
					nxt.radio = 1'b1;
				end
			end
			OP_SLEEP: begin
				if (sleep_enabled) begin
					if (!item.sender_busy && cur.wait_cnt == 2'd0) begin
						nxt.radio = 1'b0;
					end
					if (cur.wait_cnt != 2'd0) begin
						if (cur.wait_cnt >= WAIT_LIMIT) begin
							nxt.wait_cnt = 2'd0;
							if (!item.sender_busy) begin
								nxt.radio = 1'b0;
							end
						end else begin
							nxt.wait_cnt = cur.wait_cnt + 2'd1;
						end
					end
				end
			end
			default: begin
				verdict = V_TICK_DONE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/xmac_receive_frame_filter_core.sv @@
// ----------------------------------------------------------------------------
// xmac_receive_frame_filter_core
// Receive-side frame filter of a preamble-strobe radio duty-cycle layer.
// ----------------------------------------------------------------------------
// The block takes one beat per clock on the items channel while the results
// channel takes results: either a parsed received frame header or a wake or
// sleep power-cycle tick. Every beat gives exactly one result beat, in order,
// carrying the verdict and the radio power state, the busy count and the
// waiting count as they stand after that beat. A beat is captured in an input
// register, is evaluated in the following cycle against the duty-cycle state
// and the ring of recently seen strobe ids (all entries are compared in
// parallel), and lands in a result register, from which its result beat is
// offered on the results channel; the sustained rate is one beat per cycle
// while results are taken. The input register and the result register
// together let a new beat be accepted while a finished result is still
// waiting on the results channel; with the result side stalled, two beats are
// held before ready drops. The ring of seen ids is cleared to zero by reset,
// so a strobe with id zero counts as a duplicate until those entries are
// overwritten. The configuration registers (index 0 enables the duty-cycle
// layer, index 1 enables sleep-phase handling, both reset to one) are written
// through cfg_we, cfg_index and cfg_data and should only be changed while the
// block holds no beat.
// ----------------------------------------------------------------------------
`default_nettype none

module xmac_receive_frame_filter_core import xmac_rff_pkg::*; #(
	parameter int SEEN_DEPTH = SEEN_DEPTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	xmac_rff_item_if.sink     items,
	xmac_rff_result_if.source results,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic         cfg_data
);

	// Configuration registers.
	logic mac_enabled_q;
	logic sleep_enabled_q;

	// Input stage.
	item_t item_s1;
	logic  valid_s1;

	// Result stage.
	verdict_t   verdict_s2;
	logic       radio_s2;
	logic [1:0] busy_s2;
	logic [1:0] wait_s2;
	logic       valid_s2;

	// Duty-cycle state.
	mac_state_t state_q;
	mac_state_t state_nxt;
	verdict_t   verdict_nxt;
	logic       seen_insert;
	logic       seen_hit;

	logic item_accept;
	logic advance;

	// The input stage moves on whenever the result register is empty or is
	// being emptied in this cycle.
	assign advance     = valid_s1 && (!valid_s2 || results.ready);
	assign items.ready = !valid_s1 || advance;
	assign item_accept = items.valid && items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_enabled_q   <= 1'b1;
			sleep_enabled_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAC_ENABLED:   mac_enabled_q   <= cfg_data;
				REG_SLEEP_ENABLED: sleep_enabled_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			item_s1.operation     <= items.operation;
			item_s1.frame_length  <= items.frame_length;
			item_s1.parse_ok      <= items.parse_ok;
			item_s1.dispatch_byte <= items.dispatch_byte;
			item_s1.frame_kind    <= items.frame_kind;
			item_s1.frame_ident   <= items.frame_ident;
			item_s1.header_check  <= items.header_check;
			item_s1.dest_kind     <= items.dest_kind;
			item_s1.sender_busy   <= items.sender_busy;
		end
	end

	xmac_rff_seen #(
		.SEEN_DEPTH (SEEN_DEPTH)
	) u_seen (
		.clk    (clk),
		.arst_n (arst_n),
		.ident  (item_s1.frame_ident),
		.insert (seen_insert && advance),
		.hit    (seen_hit)
	);

	xmac_rff_eval u_eval (
		.item          (item_s1),
		.cur           (state_q),
		.mac_enabled   (mac_enabled_q),
		.sleep_enabled (sleep_enabled_q),
		.seen_hit      (seen_hit),
		.nxt           (state_nxt),
		.verdict       (verdict_nxt),
		.seen_insert   (seen_insert)
	);

	// The state is committed in the same cycle the beat moves to the result
	// register, so a following beat already sees it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			verdict_s2 <= verdict_nxt;
			radio_s2   <= state_nxt.radio;
			busy_s2    <= state_nxt.busy_cnt;
			wait_s2    <= state_nxt.wait_cnt;
		end
	end

	assign results.valid              = valid_s2;
	assign results.verdict            = verdict_s2;
	assign results.radio_on           = radio_s2;
	assign results.channel_busy_count = busy_s2;
	assign results.waiting_count      = wait_s2;

endmodule

`default_nettype wire

@@ rtl/xmac_rff_checker.sv @@
// ----------------------------------------------------------------------------
// xmac_rff_checker
// Port-level assertions for the receive frame filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xmac_receive_frame_filter_core_macros.svh"

module xmac_rff_checker import xmac_rff_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [3:0] verdict,
	input wire logic       radio_on,
	input wire logic [1:0] busy_count,
	input wire logic [1:0] wait_count
);

	// A stalled result keeps its contents.
	`XMAC_ASSERT_NEXT(a_result_holds, res_valid && !res_ready, res_valid && $stable(verdict) && $stable(radio_on) && $stable(busy_count) && $stable(wait_count), "stalled result changed")

	// The busy count is only ever loaded with values up to two.
	`XMAC_ASSERT_SAME(a_busy_range, res_valid, busy_count != 2'd3, "busy count out of range")

	// The waiting count wraps to zero before it could reach three.
	`XMAC_ASSERT_SAME(a_wait_range, res_valid, wait_count != 2'd3, "waiting count out of range")

	// Answering a new strobe turns the radio on and sets the busy and waiting counts to one.
	`XMAC_ASSERT_SAME(a_strobe_ack, res_valid && verdict == V_SEND_ACK, radio_on && busy_count == 2'd1 && wait_count == 2'd1, "strobe-ack state wrong")

endmodule

bind xmac_receive_frame_filter_core xmac_rff_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.verdict    (results.verdict),
	.radio_on   (results.radio_on),
	.busy_count (results.channel_busy_count),
	.wait_count (results.waiting_count)
);

`default_nettype wire
